[sv/tpg_pkg.sv]
// Shared types, codes and reset constants of the tape pulse generator.
package tpg_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 65536;

  localparam int POS_W = 17;
  localparam int LEN_W = 28;
  localparam int CFG_W = 28;
  localparam int CFG_IDX_W = 3;

  localparam logic [15:0] PILOT_LEN_RST   = 16'd2168;
  localparam logic [15:0] PILOT_CNT_RST   = 16'd3223;
  localparam logic [15:0] SYNC1_LEN_RST   = 16'd667;
  localparam logic [15:0] SYNC2_LEN_RST   = 16'd735;
  localparam logic [15:0] ZERO_LEN_RST    = 16'd855;
  localparam logic [15:0] ONE_LEN_RST     = 16'd1710;
  localparam logic [27:0] PAUSE_LEN_RST   = 28'd3500000;
  localparam logic [3:0]  FINAL_BITS_RST  = 4'd8;
  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_START = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    CFG_PILOT_LEN  = 3'd0,
    CFG_PILOT_CNT  = 3'd1,
    CFG_SYNC1_LEN  = 3'd2,
    CFG_SYNC2_LEN  = 3'd3,
    CFG_ZERO_LEN   = 3'd4,
    CFG_ONE_LEN    = 3'd5,
    CFG_PAUSE_LEN  = 3'd6,
    CFG_FINAL_BITS = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PILOT = 3'd1,
    PH_SYNC1 = 3'd2,
    PH_SYNC2 = 3'd3,
    PH_DATA  = 3'd4,
    PH_PAUSE = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  byte_value;
    logic [15:0] byte_index;
    logic        byte_is_final;
  } in_t;

  typedef struct packed {
    logic ear_level;
    logic ear_toggled;
    logic is_playing;
  } out_t;

  // Buffer write request toward the byte fetch unit.
  typedef struct packed {
    logic        en;
    logic [15:0] idx;
    logic [7:0]  data;
  } buf_wr_t;

  // Playback position control toward the byte fetch unit.
  typedef struct packed {
    logic             enter;
    logic             advance;
    logic [POS_W-1:0] rd_pos;
    logic [POS_W-1:0] pos;
  } fetch_ctl_t;

endpackage

[sv/tpg_fetch.sv]
// Block buffer memory with a prefetching cache of the current and next data byte.
module tpg_fetch #(
  parameter int unsigned BUFFER_BYTES = tpg_pkg::BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tpg_pkg::buf_wr_t   wr,
  input  tpg_pkg::fetch_ctl_t ctl,
  output logic [7:0]         byte0,
  output logic [7:0]         cur_byte,
  output logic [7:0]         nxt_byte
);
  import tpg_pkg::*;

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] q_r;
  logic [7:0] byte0_r;
  logic [7:0] cur_r;
  logic [7:0] nxt_r;
  logic       pend_r;
  logic       pend_nxt;
  logic       issue;
  logic       hit_cur;
  logic       hit_nxt;
  logic [7:0] nxt_eff;

  assign issue    = ctl.enter | ctl.advance;
  assign pend_nxt = issue;
  assign hit_cur  = wr.en && ({1'b0, wr.idx} == ctl.pos);
  assign hit_nxt  = wr.en && ({1'b0, wr.idx} == (ctl.pos + POS_W'(1)));
  // A read issued last cycle lands in q_r; it stands in for the next byte.
  assign nxt_eff  = pend_r ? q_r : nxt_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[AW'(wr.idx)] <= wr.data;
    end
    if (issue) begin
      q_r <= mem[AW'(ctl.rd_pos)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == '0)) begin
      byte0_r <= wr.data;
    end
    if (ctl.enter) begin
      cur_r <= byte0_r;
    end else if (ctl.advance) begin
      cur_r <= nxt_eff;
    end else if (hit_cur) begin
      cur_r <= wr.data;
    end
    // A write that lands with the read data is newer than the memory word.
    if (hit_nxt) begin
      nxt_r <= wr.data;
    end else if (pend_r) begin
      nxt_r <= q_r;
    end
  end

  assign byte0    = byte0_r;
  assign cur_byte = cur_r;
  assign nxt_byte = nxt_eff;

endmodule

[sv/tape_pulse_generator.sv]
// Top level of the tape pulse generator: playback sequencer, registers and result queue.
//
// The block plays one tape data block as an EAR square wave and takes one input
// transaction per clock, every clock, as long as the result side keeps up: a byte
// write, a one T-state tick, or a start that rewinds and begins playback. Each
// transaction yields exactly one result transaction, available from an output
// register backed by a skid register, so the input is stalled only when both are
// full. The block buffer is a single-port-write, single-port-read RAM with a
// registered read; no clearing pass runs after reset, and a byte never written
// reads as an unknown value. The current and next data bytes are prefetched into
// registers, with writes forwarded into them, so a tick that moves playback to
// the next byte never waits on the RAM. The rate is set by the per-tick pulse
// timer: one 28-bit increment and compare followed by the phase sequencing, all
// combinational.
module tape_pulse_generator #(
  parameter int unsigned BUFFER_BYTES = tpg_pkg::BUFFER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tpg_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tpg_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [tpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpg_pkg::CFG_W-1:0]       cfg_data
);
  import tpg_pkg::*;

  // Configuration registers.
  logic [15:0] pilot_per_r;
  logic [15:0] pilot_cnt_r;
  logic [15:0] sync_a_per_r;
  logic [15:0] sync_b_per_r;
  logic [15:0] zero_per_r;
  logic [15:0] one_len_r;
  logic [27:0] pause_len_r;
  logic [3:0]  final_bits_r;

  // Playback state.
  phase_t           phase_r, phase_nxt;
  logic [15:0]      pulses_r, pulses_nxt;
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  logic [LEN_W-1:0] elapsed_r, elapsed_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       bit_r, bit_nxt;
  logic             ear_r, ear_nxt;
  logic [POS_W-1:0] blen_r, blen_nxt;

  // Result queue: output register plus one skid entry.
  logic out_vld_r;
  logic skid_vld_r;
  out_t out_q_r;
  out_t skid_q_r;

  logic       in_acc;
  logic       pop;
  logic       wr_in_range;
  out_t       res;
  logic       toggled;
  buf_wr_t    wr;
  fetch_ctl_t ctl;
  logic [7:0] byte0;
  logic [7:0] cur_byte;
  logic [7:0] nxt_byte;

  // Sequencer scratch values.
  logic             run_np;
  phase_t           np_ph;
  logic             do_data;
  logic             entering;
  logic             adv;
  logic             to_pause;
  logic [POS_W-1:0] pos_b;
  logic [3:0]       bit_b;
  logic [3:0]       bits_lim;
  logic [3:0]       final_sat;
  logic [7:0]       data_byte;
  logic [LEN_W-1:0] el_inc;
  logic [15:0]      pulses_dec;

  assign in_stall    = skid_vld_r;
  assign in_acc      = in_valid && !in_stall;
  assign pop         = out_vld_r && !out_stall;
  assign wr_in_range = 32'(in_data.byte_index) < BUFFER_BYTES;
  assign final_sat   = (final_bits_r > BITS_PER_BYTE) ? BITS_PER_BYTE : final_bits_r;

  assign wr.en   = in_acc && (in_data.func == FUNC_WRITE) && wr_in_range;
  assign wr.idx  = in_data.byte_index;
  assign wr.data = in_data.byte_value;

  tpg_fetch #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_fetch (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .ctl      (ctl),
    .byte0    (byte0),
    .cur_byte (cur_byte),
    .nxt_byte (nxt_byte)
  );

  // The user must write configuration only while no transaction is in flight; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pilot_per_r  <= PILOT_LEN_RST;
      pilot_cnt_r  <= PILOT_CNT_RST;
      sync_a_per_r <= SYNC1_LEN_RST;
      sync_b_per_r <= SYNC2_LEN_RST;
      zero_per_r   <= ZERO_LEN_RST;
      one_len_r    <= ONE_LEN_RST;
      pause_len_r  <= PAUSE_LEN_RST;
      final_bits_r <= FINAL_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PILOT_LEN:  pilot_per_r  <= cfg_data[15:0];
        CFG_PILOT_CNT:  pilot_cnt_r  <= cfg_data[15:0];
        CFG_SYNC1_LEN:  sync_a_per_r <= cfg_data[15:0];
        CFG_SYNC2_LEN:  sync_b_per_r <= cfg_data[15:0];
        CFG_ZERO_LEN:   zero_per_r   <= cfg_data[15:0];
        CFG_ONE_LEN:    one_len_r    <= cfg_data[15:0];
        CFG_PAUSE_LEN:  pause_len_r  <= cfg_data[27:0];
        CFG_FINAL_BITS: final_bits_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer: block length, timer, pulse counting and phase changes for one transaction.
  always_comb begin
    phase_nxt   = phase_r;
    pulses_nxt  = pulses_r;
    cur_len_nxt = cur_len_r;
    elapsed_nxt = elapsed_r;
    pos_nxt     = pos_r;
    bit_nxt     = bit_r;
    ear_nxt     = ear_r;
    blen_nxt    = blen_r;
    toggled     = 1'b0;
    run_np      = 1'b0;
    np_ph       = phase_r;
    do_data     = 1'b0;
    entering    = 1'b0;
    adv         = 1'b0;
    to_pause    = 1'b0;
    pos_b       = pos_r;
    bit_b       = bit_r;
    bits_lim    = BITS_PER_BYTE;
    data_byte   = cur_byte;
    el_inc      = elapsed_r + LEN_W'(1);
    pulses_dec  = (pulses_r != '0) ? (pulses_r - 16'd1) : '0;

    if (in_acc) begin
      case (func_t'(in_data.func))
        FUNC_WRITE: begin
          if (wr_in_range && in_data.byte_is_final) begin
            blen_nxt = {1'b0, in_data.byte_index} + POS_W'(1);
          end
        end
        FUNC_TICK: begin
          if (phase_r != PH_IDLE) begin
            if (el_inc >= cur_len_r) begin
              elapsed_nxt = '0;
              ear_nxt     = ~ear_r;
              toggled     = 1'b1;
              pulses_nxt  = pulses_dec;
              if (pulses_dec == '0) begin
                run_np = 1'b1;
                np_ph  = phase_r;
              end
            end else begin
              elapsed_nxt = el_inc;
            end
          end
        end
        FUNC_START: begin
          // Rewind, then take the first phase step from idle.
          phase_nxt   = PH_IDLE;
          pulses_nxt  = '0;
          elapsed_nxt = '0;
          cur_len_nxt = LEN_W'(1);
          pos_nxt     = '0;
          bit_nxt     = '0;
          ear_nxt     = 1'b0;
          run_np      = 1'b1;
          np_ph       = PH_IDLE;
        end
        default: ;
      endcase
    end

    if (run_np) begin
      case (np_ph)
        PH_IDLE: begin
          if (pilot_cnt_r != '0) begin
            phase_nxt   = PH_PILOT;
            pulses_nxt  = pilot_cnt_r;
            cur_len_nxt = LEN_W'(pilot_per_r);
          end else begin
            do_data  = 1'b1;
            entering = 1'b1;
          end
        end
        PH_PILOT: begin
          phase_nxt   = PH_SYNC1;
          pulses_nxt  = 16'd1;
          cur_len_nxt = LEN_W'(sync_a_per_r);
        end
        PH_SYNC1: begin
          phase_nxt   = PH_SYNC2;
          pulses_nxt  = 16'd1;
          cur_len_nxt = LEN_W'(sync_b_per_r);
        end
        PH_SYNC2: begin
          do_data  = 1'b1;
          entering = 1'b1;
        end
        PH_DATA: begin
          do_data = 1'b1;
        end
        default: begin
          // End of the pause pulse: playback stops and EAR returns low.
          phase_nxt   = PH_IDLE;
          pulses_nxt  = '0;
          elapsed_nxt = '0;
          cur_len_nxt = LEN_W'(1);
          pos_nxt     = '0;
          bit_nxt     = '0;
          ear_nxt     = 1'b0;
        end
      endcase

      if (do_data) begin
        pos_b = entering ? '0 : pos_r;
        bit_b = entering ? '0 : (bit_r + 4'd1);
        if (pos_b >= blen_r) begin
          to_pause = 1'b1;
        end else begin
          // Only the last byte of the block may be cut short.
          bits_lim = (pos_b == (blen_r - POS_W'(1))) ? final_sat : BITS_PER_BYTE;
          if (bit_b >= bits_lim) begin
            bit_b = '0;
            pos_b = pos_b + POS_W'(1);
            adv   = 1'b1;
            if (pos_b >= blen_r) begin
              to_pause = 1'b1;
            end
          end
        end
        pos_nxt = pos_b;
        bit_nxt = bit_b;
        if (to_pause) begin
          phase_nxt   = PH_PAUSE;
          pulses_nxt  = 16'd1;
          cur_len_nxt = pause_len_r;
        end else begin
          data_byte   = entering ? byte0 : (adv ? nxt_byte : cur_byte);
          phase_nxt   = PH_DATA;
          pulses_nxt  = 16'd2;
          cur_len_nxt = data_byte[~bit_b[2:0]] ? LEN_W'(one_len_r) : LEN_W'(zero_per_r);
        end
      end

      // A zero-length pulse ends playback on the spot.
      if ((phase_nxt != PH_IDLE) && (cur_len_nxt == '0)) begin
        phase_nxt   = PH_IDLE;
        pulses_nxt  = '0;
        elapsed_nxt = '0;
        cur_len_nxt = LEN_W'(1);
        pos_nxt     = '0;
        bit_nxt     = '0;
        ear_nxt     = 1'b0;
      end
    end

    res.ear_level   = ear_nxt;
    res.ear_toggled = toggled;
    res.is_playing  = (phase_nxt != PH_IDLE);
  end

  // The fetch unit reloads on entering data and prefetches one byte ahead.
  assign ctl.enter   = do_data && entering;
  assign ctl.advance = do_data && adv;
  assign ctl.rd_pos  = pos_b + POS_W'(1);
  assign ctl.pos     = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulses_r  <= '0;
      cur_len_r <= LEN_W'(1);
      elapsed_r <= '0;
      pos_r     <= '0;
      bit_r     <= '0;
      ear_r     <= 1'b0;
      blen_r    <= '0;
    end else begin
      pulses_r  <= pulses_nxt;
      cur_len_r <= cur_len_nxt;
      elapsed_r <= elapsed_nxt;
      pos_r     <= pos_nxt;
      bit_r     <= bit_nxt;
      ear_r     <= ear_nxt;
      blen_r    <= blen_nxt;
    end
  end

  // Result queue. The skid entry fills only when the output register is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_q_r <= skid_q_r;
      end
    end else if (in_acc) begin
      if (out_vld_r && !pop) begin
        skid_q_r <= res;
      end else begin
        out_q_r <= res;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_q_r;

  // The pulse timer is cleared whenever playback is stopped.
  a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (elapsed_r == '0))
    else $error("pulse timer not cleared while stopped");

  // A running pulse never has zero length.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (cur_len_r != '0))
    else $error("zero-length pulse left running");

  // The skid entry holds a transaction only behind a held output register.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry valid with empty output register");

  // A transaction that reaches an empty queue shows up at the output next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_vld_r) |=> out_vld_r)
    else $error("accepted transaction produced no result");

endmodule

[tb/tpg_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the tape pulse generator: watches all ports, predicts EAR status, compares.
module tpg_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  tpg_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  tpg_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [tpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpg_pkg::CFG_W-1:0]     cfg_data,
  output int unsigned                   mismatches,
  output int unsigned                   pending,
  output int unsigned                   results_checked,
  output int unsigned                   edges_seen
);
  import tpg_pkg::*;

  // Configuration copy.
  logic [15:0] pilot_width, pilot_cnt, sync_a_width, sync_b_width, zero_width, one_len;
  logic [27:0] pause_len;
  logic [3:0]  final_bits;

  // Playback state copy.
  logic [7:0]  tape_mem [0:65535];
  logic [16:0] blk_len;
  phase_t      ph;
  logic [15:0] pulses_left;
  logic [27:0] pulse_len;
  logic [27:0] elapsed;
  logic [16:0] byte_pos;
  logic [3:0]  bit_pos;
  logic        ear;

  out_t expected_status [$];

  function automatic void rewind_tape();
    ph          = PH_IDLE;
    pulses_left = '0;
    elapsed     = '0;
    pulse_len   = 28'd1;
    byte_pos    = '0;
    bit_pos     = '0;
    ear         = 1'b0;
  endfunction

  // Set up the two pulses of the next data bit; returns 0 once the data part is over.
  function automatic bit pick_bit();
    logic [3:0] nbits;
    logic [7:0] b;
    if (byte_pos >= blk_len) return 1'b0;
    nbits = 4'd8;
    if (byte_pos == blk_len - 17'd1) nbits = (final_bits > 4'd8) ? 4'd8 : final_bits;
    if (bit_pos >= nbits) begin
      bit_pos  = '0;
      byte_pos = byte_pos + 17'd1;
      if (byte_pos >= blk_len) return 1'b0;
    end
    b           = tape_mem[byte_pos[15:0]];
    pulse_len   = b[3'd7 - bit_pos[2:0]] ? {12'd0, one_len} : {12'd0, zero_width};
    pulses_left = 16'd2;
    return 1'b1;
  endfunction

  function automatic void enter_pause();
    ph          = PH_PAUSE;
    pulses_left = 16'd1;
    pulse_len   = pause_len;
  endfunction

  function automatic void enter_data();
    ph       = PH_DATA;
    byte_pos = '0;
    bit_pos  = '0;
    if (!pick_bit()) enter_pause();
  endfunction

  function automatic void advance_phase();
    case (ph)
      PH_IDLE: begin
        if (pilot_cnt != 16'd0) begin
          ph          = PH_PILOT;
          pulses_left = pilot_cnt;
          pulse_len   = {12'd0, pilot_width};
        end else begin
          enter_data();
        end
      end
      PH_PILOT: begin
        ph          = PH_SYNC1;
        pulses_left = 16'd1;
        pulse_len   = {12'd0, sync_a_width};
      end
      PH_SYNC1: begin
        ph          = PH_SYNC2;
        pulses_left = 16'd1;
        pulse_len   = {12'd0, sync_b_width};
      end
      PH_SYNC2: enter_data();
      PH_DATA: begin
        bit_pos = bit_pos + 4'd1;
        if (!pick_bit()) enter_pause();
      end
      default: rewind_tape();
    endcase
    // A pulse of zero length ends playback on the spot.
    if (ph != PH_IDLE && pulse_len == 28'd0) rewind_tape();
  endfunction

  function automatic out_t play_step(in_t t);
    out_t r;
    logic tog;
    tog = 1'b0;
    case (t.func)
      FUNC_WRITE: begin
        tape_mem[t.byte_index] = t.byte_value;
        if (t.byte_is_final) blk_len = {1'b0, t.byte_index} + 17'd1;
      end
      FUNC_TICK: begin
        if (ph != PH_IDLE) begin
          elapsed = elapsed + 28'd1;
          if (elapsed >= pulse_len) begin
            elapsed = '0;
            ear     = ~ear;
            tog     = 1'b1;
            if (pulses_left != 16'd0) pulses_left = pulses_left - 16'd1;
            if (pulses_left == 16'd0) advance_phase();
          end
        end
      end
      FUNC_START: begin
        rewind_tape();
        advance_phase();
      end
      default: ;
    endcase
    r.ear_level   = ear;
    r.ear_toggled = tog;
    r.is_playing  = (ph != PH_IDLE);
    return r;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_PILOT_LEN:  pilot_width  = val[15:0];
      CFG_PILOT_CNT:  pilot_cnt    = val[15:0];
      CFG_SYNC1_LEN:  sync_a_width = val[15:0];
      CFG_SYNC2_LEN:  sync_b_width = val[15:0];
      CFG_ZERO_LEN:   zero_width   = val[15:0];
      CFG_ONE_LEN:    one_len      = val[15:0];
      CFG_PAUSE_LEN:  pause_len    = val;
      CFG_FINAL_BITS: final_bits   = val[3:0];
      default: ;
    endcase
  endfunction

  function automatic int unsigned field_diff(string name, logic want, logic got);
    if (want === got) return 0;
    $display("%0t ns: %s mismatch, expected %b, actual %b", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    out_t        want;
    int unsigned bad;
    bad = 0;
    if (!rst_n) begin
      pilot_width  = PILOT_LEN_RST;
      pilot_cnt    = PILOT_CNT_RST;
      sync_a_width = SYNC1_LEN_RST;
      sync_b_width = SYNC2_LEN_RST;
      zero_width   = ZERO_LEN_RST;
      one_len      = ONE_LEN_RST;
      pause_len    = PAUSE_LEN_RST;
      final_bits   = FINAL_BITS_RST;
      blk_len      = '0;
      rewind_tape();
      expected_status.delete();
      pending         <= 0;
      mismatches      <= 0;
      results_checked <= 0;
      edges_seen      <= 0;
    end else begin
      if (cfg_we) apply_cfg(cfg_index, cfg_data);
      // Retire a result first: it always belongs to an earlier transaction.
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %b", $time, out_data);
          bad++;
        end else begin
          want = expected_status.pop_front();
          bad += field_diff("ear_level", want.ear_level, out_data.ear_level);
          bad += field_diff("ear_toggled", want.ear_toggled, out_data.ear_toggled);
          bad += field_diff("is_playing", want.is_playing, out_data.is_playing);
        end
        results_checked <= results_checked + 1;
        if (out_data.ear_toggled === 1'b1) edges_seen <= edges_seen + 1;
      end
      if (in_valid && !in_stall) expected_status.push_back(play_step(in_data));
      pending    <= expected_status.size();
      mismatches <= mismatches + bad;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top of the tape pulse generator testbench: clock, reset, stimulus, back pressure and verdict.
module tb_top;
  import tpg_pkg::*;

  // The input encoding has one code the block does not define; it must be ignored.
  localparam logic [1:0]  FUNC_NONE = 2'd3;
  localparam logic [27:0] PAUSE_MAX = 28'd229372500;
  // Bytes 0..PREFIX_BYTES-1 are written early, so a block ending at or below
  // PREFIX_BYTES-2 never touches a location that was never written, even when
  // the block prefetches one byte ahead.
  localparam int PREFIX_BYTES = 4;
  localparam int RANDOM_ITEMS = 370;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int unsigned mismatches, pending, results_checked, edges_seen;

  // Sender pacing: transactions go out in bursts; between bursts the sender may idle.
  int unsigned burst_left;
  bit          no_gaps;
  int unsigned items_sent;
  int unsigned setups_run;

  tape_pulse_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tpg_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .edges_seen      (edges_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs or never drains.
  initial begin
    #3ms;
    $display("tape_pulse_generator regression: fail");
    $finish;
  end

  function automatic in_t mk_item(logic [1:0] f, logic [7:0] v, logic [15:0] idx, logic fin);
    in_t t;
    t.func          = f;
    t.byte_value    = v;
    t.byte_index    = idx;
    t.byte_is_final = fin;
    return t;
  endfunction

  function automatic logic [27:0] one_of3(logic [27:0] a, logic [27:0] b, logic [27:0] c);
    case ($urandom_range(0, 2))
      0:       return a;
      1:       return b;
      default: return c;
    endcase
  endfunction

  // Offer one transaction and hold it until the block takes it. Valid is only
  // lowered at the start of a gap, never in the step where it is raised again.
  task automatic send(in_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and let every outstanding result drain. Each transaction gives
  // exactly one result, so spare cycles after the drain cover the output and skid registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [27:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_cfg(logic [15:0] pl, pc, s1, s2, zl, ol, logic [27:0] pa,
                             logic [3:0] fb);
    cfg_write(CFG_PILOT_LEN, {12'd0, pl});
    cfg_write(CFG_PILOT_CNT, {12'd0, pc});
    cfg_write(CFG_SYNC1_LEN, {12'd0, s1});
    cfg_write(CFG_SYNC2_LEN, {12'd0, s2});
    cfg_write(CFG_ZERO_LEN, {12'd0, zl});
    cfg_write(CFG_ONE_LEN, {12'd0, ol});
    cfg_write(CFG_PAUSE_LEN, pa);
    cfg_write(CFG_FINAL_BITS, {24'd0, fb});
  endtask

  // One random playback setup: fresh registers, a short block, a start, then
  // mostly ticks with some writes, ignored codes and restarts mixed in. Every
  // fourth setup pushes the registers to their extremes.
  task automatic random_setup(int unsigned setup_no, inout int unsigned random_items);
    logic [15:0] pl, pc, s1, s2, zl, ol;
    logic [27:0] pa;
    logic [3:0]  fb;
    int unsigned nbytes, pick, n;
    longint      est, longest;
    wait_idle();
    no_gaps = ($urandom_range(0, 2) == 0);
    if (setup_no % 4 == 1) begin
      pl = 16'(one_of3(28'd0, 28'd1, 28'hFFFF));
      pc = 16'(one_of3(28'd0, 28'd1, 28'hFFFF));
      s1 = 16'(one_of3(28'd0, 28'd1, 28'hFFFF));
      s2 = 16'(one_of3(28'd0, 28'd1, 28'hFFFF));
      zl = $urandom_range(0, 1) ? 16'd1 : 16'hFFFF;
      ol = $urandom_range(0, 1) ? 16'd1 : 16'hFFFF;
      pa = one_of3(28'd0, 28'd1, PAUSE_MAX);
      fb = 4'(one_of3(28'd0, 28'd8, 28'd15));
    end else begin
      pl = 16'($urandom_range(1, 3));
      pc = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
      s1 = ($urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
      s2 = ($urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
      zl = 16'($urandom_range(1, 2));
      ol = 16'($urandom_range(1, 3));
      pa = 28'($urandom_range(0, 4));
      fb = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    end
    program_cfg(pl, pc, s1, s2, zl, ol, pa, fb);

    nbytes = $urandom_range(1, PREFIX_BYTES - 1);
    for (int i = 0; i < nbytes; i++) begin
      send(mk_item(FUNC_WRITE, 8'($urandom), 16'(i), i == nbytes - 1));
    end
    send(mk_item(FUNC_START, 8'($urandom), 16'($urandom), 1'($urandom)));

    // Roughly as many ticks as a full playback needs, capped for the slow settings.
    longest = (zl > ol) ? longint'(zl) : longint'(ol);
    est = longint'(pc) * longint'(pl) + longint'(s1) + longint'(s2)
        + longint'(nbytes) * 16 * longest + longint'(pa) + 8;
    if (est > 220) est = 220;
    if (est < 40) est = 40;
    n = 32'(est);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 86) begin
        send(mk_item(FUNC_TICK, 8'($urandom), 16'($urandom), 1'($urandom)));
      end else if (pick < 90) begin
        // A write anywhere in the buffer that leaves the block length alone.
        send(mk_item(FUNC_WRITE, 8'($urandom), 16'($urandom), 1'b0));
      end else if (pick < 93) begin
        // Rewrite a block byte, possibly moving the end of the block mid-play.
        send(mk_item(FUNC_WRITE, 8'($urandom), 16'($urandom_range(0, PREFIX_BYTES - 2)),
                     1'($urandom)));
      end else if (pick < 96) begin
        send(mk_item(FUNC_NONE, 8'($urandom), 16'($urandom), 1'($urandom)));
      end else begin
        send(mk_item(FUNC_START, 8'($urandom), 16'($urandom), 1'($urandom)));
      end
    end
    random_items += nbytes + 1 + n;
    setups_run++;
  endtask

  // Receiver: stalls on its own schedule of segments. Some segments never stall,
  // some stall lightly or heavily, some alternate. The sixth segment, and now and
  // then a later one, is a long hold-off that fills the block and backs up its input.
  initial begin : receiver
    int unsigned seg_no, kind, seg_len;
    seg_no = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (seg_no == 5 || (seg_no > 5 && $urandom_range(0, 15) == 0)) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
      end else begin
        kind    = $urandom_range(0, 3);
        seg_len = $urandom_range(16, 80);
        for (int i = 0; i < seg_len; i++) begin
          case (kind)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= i[0];
          endcase
          @(posedge clk);
        end
      end
      seg_no++;
    end
  end

  // Sender: directed checks first, then random playback setups, then the verdict.
  initial begin : stimulus
    int unsigned random_items;
    int unsigned setup_no;
    random_items = 0;
    setup_no     = 0;
    items_sent   = 0;
    setups_run   = 0;
    burst_left   = 0;
    no_gaps      = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-tick pulses everywhere but the two-tick one bit, so each phase of playback is short.
    program_cfg(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 28'd1, 4'd8);

    // A tick with nothing playing changes nothing; the undefined code is ignored.
    send(mk_item(FUNC_TICK, 8'h00, 16'h0000, 1'b0));
    send(mk_item(FUNC_NONE, 8'hFF, 16'hFFFF, 1'b1));
    // Fill the start of the buffer and the last location, without setting a length.
    send(mk_item(FUNC_WRITE, 8'h00, 16'd0, 1'b0));
    send(mk_item(FUNC_WRITE, 8'hFF, 16'd1, 1'b0));
    send(mk_item(FUNC_WRITE, 8'hA5, 16'd2, 1'b0));
    send(mk_item(FUNC_WRITE, 8'h5A, 16'd3, 1'b0));
    send(mk_item(FUNC_WRITE, 8'h3C, 16'hFFFF, 1'b0));
    // Empty block: pilot, both syncs, then straight into the pause, which ends low.
    send(mk_item(FUNC_START, 8'h00, 16'h0000, 1'b0));
    repeat (4) send(mk_item(FUNC_TICK, 8'h00, 16'h0000, 1'b0));
    // Restart in the middle of playback, then give the block a length of one byte while it plays.
    send(mk_item(FUNC_START, 8'h00, 16'h0000, 1'b0));
    send(mk_item(FUNC_TICK, 8'h00, 16'h0000, 1'b0));
    send(mk_item(FUNC_START, 8'h00, 16'h0000, 1'b0));
    send(mk_item(FUNC_WRITE, 8'h80, 16'd0, 1'b1));
    wait_idle();

    // No pilot and no bits from the last byte: the start lands in the pause.
    cfg_write(CFG_PILOT_CNT, 28'd0);
    cfg_write(CFG_FINAL_BITS, 28'd0);
    send(mk_item(FUNC_START, 8'h00, 16'h0000, 1'b0));
    send(mk_item(FUNC_TICK, 8'h00, 16'h0000, 1'b0));
    wait_idle();

    // A pilot pulse of zero length stops playback on the start itself.
    cfg_write(CFG_PILOT_CNT, 28'd1);
    cfg_write(CFG_PILOT_LEN, 28'd0);
    send(mk_item(FUNC_START, 8'h00, 16'h0000, 1'b0));
    wait_idle();

    // Two data bits of 0x80 with no pilot: a one bit, a zero bit, then the pause.
    cfg_write(CFG_PILOT_CNT, 28'd0);
    cfg_write(CFG_FINAL_BITS, 28'd2);
    send(mk_item(FUNC_START, 8'h00, 16'h0000, 1'b0));
    repeat (7) send(mk_item(FUNC_TICK, 8'h00, 16'h0000, 1'b0));

    while (random_items < RANDOM_ITEMS) begin
      random_setup(setup_no, random_items);
      setup_no++;
    end

    // Drain, then allow the output and skid registers time to show anything stray.
    wait_idle();
    repeat (8) @(posedge clk);

    $display("Covered %0d transactions over %0d random playback setups plus directed cases;",
             items_sent, setups_run);
    $display("%0d results compared, %0d of them EAR edges.", results_checked, edges_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("tape_pulse_generator regression: pass");
    end else begin
      $display("tape_pulse_generator regression: fail");
    end
    $finish;
  end

endmodule
